// File: hw/rtl/lpb_pkg.sv
package lpb_pkg;

   localparam int FRAC_BITS = 20;

   localparam int COL_W  = 12;
   localparam int ROW_W  = 12;
   localparam int RHO_W  = 23;
   localparam int F_W    = 24;
   localparam int GW_W   = 13;
   localparam int SIDE_W = 2;
   localparam int NUM_DIR = 9;

   localparam logic [GW_W-1:0] GW_RESET = GW_W'(256);

   // Signed width of the normal momentum; the fill dividends take one bit more.
   localparam int M_W   = 28;
   localparam int X_W   = M_W + 1;
   localparam int SUM_W = X_W + 1;
   localparam int NW    = M_W + FRAC_BITS;

   // Quotient bits produced by the divider chain, one per cell.
   localparam int QB = F_W + 1;

   // Division by three as a multiply by the reciprocal and one correction.
   localparam int DIV3_SHIFT = 30;
   localparam int R3_W       = 29;
   localparam logic [R3_W-1:0] R3 = R3_W'((64'd1 << DIV3_SHIFT) / 3);
   localparam int PROD_W     = X_W + R3_W;

   localparam logic signed [F_W-1:0] Q_MAX = {1'b0, {(F_W-1){1'b1}}};
   localparam logic signed [F_W-1:0] Q_MIN = {1'b1, {(F_W-1){1'b0}}};
   localparam logic [QB-1:0] QPOS_LIM = QB'((64'd1 << (F_W-1)) - 1);
   localparam logic [QB-1:0] QNEG_LIM = QB'(64'd1 << (F_W-1));

   localparam int COL_LSB = 0;
   localparam int ROW_LSB = COL_LSB + COL_W;
   localparam int RHO_LSB = ROW_LSB + ROW_W;
   localparam int F0_LSB  = RHO_LSB + RHO_W;
   localparam int IN_USED = F0_LSB + NUM_DIR * F_W;
   localparam int IN_W    = ((IN_USED + 7) / 8) * 8;

   localparam int OUT_USED = ROW_W + RHO_W + 5 * F_W + 1;
   localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

   localparam int BUF_DEPTH = 2;

   typedef enum logic [SIDE_W-1:0] {
      SIDE_WEST = 2'd0,
      SIDE_EAST = 2'd1,
      SIDE_NONE = 2'd2
   } side_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      side_type                side;
      logic [RHO_W-1:0]        rho;
      logic signed [F_W-1:0]   fill_first;
      logic signed [F_W-1:0]   fill_second;
      logic signed [F_W-1:0]   fill_third;
      logic                    fill_sat;
      logic                    m_neg;
      logic                    m_zero;
      logic                    rho_zero;
      logic                    ovf;
      logic [RHO_W-1:0]        rem;
      logic [QB-1:0]           nlow;
      logic [QB-1:0]           quot;
   } chain_type;

   typedef struct packed {
      side_type          side;
      logic [OUT_W-1:0]  data;
   } res_type;

endpackage

// File: hw/rtl/lpb_front.sv
module lpb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [lpb_pkg::IN_W-1:0]    in_data,
   input  logic                        csr_wr_en,
   input  logic [lpb_pkg::GW_W-1:0]    csr_wr_data,
   output logic                        out_valid,
   output lpb_pkg::chain_type          out_data
);

   localparam int X_W = lpb_pkg::X_W;
   localparam int M_W = lpb_pkg::M_W;
   localparam int F_W = lpb_pkg::F_W;

   function automatic logic [X_W-1:0] mag_x(input logic signed [X_W-1:0] v);
      mag_x = v[X_W-1] ? X_W'(-v) : X_W'(v);
   endfunction

   function automatic logic signed [X_W-1:0] div3_fix(
      input logic [lpb_pkg::PROD_W-1:0] p,
      input logic [X_W-1:0]             x,
      input logic                       neg
   );
      logic [X_W-1:0] q0;
      logic [X_W-1:0] r;
      logic [X_W-1:0] q;
      q0 = X_W'(p[lpb_pkg::PROD_W-1:lpb_pkg::DIV3_SHIFT]);
      r  = x - (q0 + (q0 << 1));
      q  = (r >= X_W'(3)) ? q0 + 1'b1 : q0;
      div3_fix = neg ? $signed(X_W'(-q)) : $signed(q);
   endfunction

   function automatic logic signed [F_W-1:0] clamp_q(
      input  logic signed [lpb_pkg::SUM_W-1:0] v,
      output logic                             sat
   );
      sat = 1'b0;
      if (v > lpb_pkg::SUM_W'(lpb_pkg::Q_MAX)) begin
         sat = 1'b1;
         clamp_q = lpb_pkg::Q_MAX;
      end else if (v < lpb_pkg::SUM_W'(lpb_pkg::Q_MIN)) begin
         sat = 1'b1;
         clamp_q = lpb_pkg::Q_MIN;
      end else begin
         clamp_q = F_W'(v);
      end
   endfunction

   logic [lpb_pkg::GW_W-1:0] grid_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= lpb_pkg::GW_RESET;
      end else if (csr_wr_en) begin
         grid_width_ff <= csr_wr_data;
      end
   end

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic out_valid_ff;

   logic [lpb_pkg::COL_W-1:0] s1_col_ff;
   logic [lpb_pkg::ROW_W-1:0] s1_row_ff, s2_row_ff, s3_row_ff, s4_row_ff, s5_row_ff, s6_row_ff;
   logic [lpb_pkg::RHO_W-1:0] s1_rho_ff, s2_rho_ff, s3_rho_ff, s4_rho_ff, s5_rho_ff, s6_rho_ff;
   logic signed [F_W-1:0]     s1_f_ff [lpb_pkg::NUM_DIR];

   lpb_pkg::side_type s1_side;
   lpb_pkg::side_type s2_side_ff, s3_side_ff, s4_side_ff, s5_side_ff, s6_side_ff;

   logic signed [F_W-1:0] s1_base [3];
   logic signed [F_W-1:0] s2_base_ff [3];
   logic signed [F_W-1:0] s3_base_ff [3];
   logic signed [F_W-1:0] s4_base_ff [3];
   logic signed [F_W-1:0] s5_base_ff [3];
   logic signed [F_W-1:0] s6_base_ff [3];

   logic signed [M_W-1:0] s1_ext [lpb_pkg::NUM_DIR];
   logic signed [M_W-1:0] s1_sc, s1_sw, s1_se, s1_d;
   logic signed [M_W-1:0] s2_sc_ff, s2_sw_ff, s2_se_ff, s2_d_ff;
   logic [lpb_pkg::GW_W-1:0] gw_last;

   logic signed [M_W-1:0] s2_rho_s, s2_m, s2_d3;
   logic signed [M_W-1:0] s3_m_ff, s3_d3_ff;

   logic signed [X_W-1:0] s3_t2, s3_tb, s3_tc;
   logic [X_W-1:0]        s3_mag_m, s3_xa, s3_xb, s3_xc;
   logic [lpb_pkg::NW-1:0] s3_n;

   logic [X_W-1:0]         s4_xa_ff, s4_xb_ff, s4_xc_ff;
   logic                   s4_na_ff, s4_nb_ff, s4_nc_ff;
   logic [lpb_pkg::NW-1:0] s4_n_ff;
   logic                   s4_m_neg_ff, s4_m_zero_ff, s4_rho_zero_ff;

   logic [lpb_pkg::PROD_W-1:0] s4_pa, s4_pb, s4_pc;
   logic [lpb_pkg::NW-1:0]     s4_top;
   logic                       s4_ovf;

   logic [lpb_pkg::PROD_W-1:0] s5_pa_ff, s5_pb_ff, s5_pc_ff;
   logic [X_W-1:0]             s5_xa_ff, s5_xb_ff, s5_xc_ff;
   logic                       s5_na_ff, s5_nb_ff, s5_nc_ff;
   logic                       s5_m_neg_ff, s5_m_zero_ff, s5_rho_zero_ff, s5_ovf_ff;
   logic [lpb_pkg::RHO_W-1:0]  s5_rem_ff;
   logic [lpb_pkg::QB-1:0]     s5_nlow_ff;

   logic signed [X_W-1:0]      s6_qa_ff, s6_qb_ff, s6_qc_ff;
   logic                       s6_m_neg_ff, s6_m_zero_ff, s6_rho_zero_ff, s6_ovf_ff;
   logic [lpb_pkg::RHO_W-1:0]  s6_rem_ff;
   logic [lpb_pkg::QB-1:0]     s6_nlow_ff;

   logic signed [lpb_pkg::SUM_W-1:0] s6_sa, s6_sb, s6_sc;
   logic signed [F_W-1:0]            s6_fa, s6_fb, s6_fc;
   logic                             s6_sat_a, s6_sat_b, s6_sat_c;
   lpb_pkg::chain_type               out_data_in, out_data_ff;

   // Stage 1: side decision and partial sums.
   assign gw_last = grid_width_ff - lpb_pkg::GW_W'(1);

   always_comb begin
      priority if (s1_col_ff == '0) begin
         s1_side = lpb_pkg::SIDE_WEST;
      end else if ({1'b0, s1_col_ff} == gw_last) begin
         s1_side = lpb_pkg::SIDE_EAST;
      end else begin
         s1_side = lpb_pkg::SIDE_NONE;
      end
   end

   always_comb begin
      for (int k = 0; k < lpb_pkg::NUM_DIR; k++) begin
         s1_ext[k] = M_W'(s1_f_ff[k]);
      end
      s1_sc = s1_ext[0] + s1_ext[2] + s1_ext[4];
      s1_sw = s1_ext[3] + s1_ext[6] + s1_ext[7];
      s1_se = s1_ext[1] + s1_ext[5] + s1_ext[8];
      s1_d  = s1_ext[4] - s1_ext[2];
      if (s1_side == lpb_pkg::SIDE_WEST) begin
         s1_base[0] = s1_f_ff[3];
         s1_base[1] = s1_f_ff[7];
         s1_base[2] = s1_f_ff[6];
      end else begin
         s1_base[0] = s1_f_ff[1];
         s1_base[1] = s1_f_ff[5];
         s1_base[2] = s1_f_ff[8];
      end
   end

   // Stage 2: normal momentum.
   always_comb begin
      s2_rho_s = $signed(M_W'(s2_rho_ff));
      if (s2_side_ff == lpb_pkg::SIDE_WEST) begin
         s2_m = s2_rho_s - (s2_sc_ff + (s2_sw_ff <<< 1));
      end else begin
         s2_m = (s2_sc_ff + (s2_se_ff <<< 1)) - s2_rho_s;
      end
      s2_d3 = s2_d_ff + (s2_d_ff <<< 1);
   end

   // Stage 3: magnitudes of the dividends.
   always_comb begin
      s3_t2    = X_W'(s3_m_ff) <<< 1;
      s3_tb    = X_W'(s3_m_ff) + X_W'(s3_d3_ff);
      s3_tc    = X_W'(s3_m_ff) - X_W'(s3_d3_ff);
      s3_mag_m = mag_x(X_W'(s3_m_ff));
      s3_xa    = mag_x(s3_t2) + X_W'(1);
      s3_xb    = (mag_x(s3_tb) + X_W'(3)) >> 1;
      s3_xc    = (mag_x(s3_tc) + X_W'(3)) >> 1;
      s3_n     = (lpb_pkg::NW'(s3_mag_m) << lpb_pkg::FRAC_BITS)
                 + lpb_pkg::NW'(s3_rho_ff >> 1);
   end

   // Stage 4: reciprocal products and divider overflow check.
   always_comb begin
      s4_pa  = s4_xa_ff * lpb_pkg::R3;
      s4_pb  = s4_xb_ff * lpb_pkg::R3;
      s4_pc  = s4_xc_ff * lpb_pkg::R3;
      s4_top = s4_n_ff >> lpb_pkg::QB;
      s4_ovf = s4_top >= lpb_pkg::NW'(s4_rho_ff);
   end

   // Stage 6: apply the fills and saturate on a boundary side; other nodes pass their bases through.
   always_comb begin
      if (s6_side_ff == lpb_pkg::SIDE_EAST) begin
         s6_sa = lpb_pkg::SUM_W'(s6_base_ff[0]) - lpb_pkg::SUM_W'(s6_qa_ff);
         s6_sb = lpb_pkg::SUM_W'(s6_base_ff[1]) - lpb_pkg::SUM_W'(s6_qb_ff);
         s6_sc = lpb_pkg::SUM_W'(s6_base_ff[2]) - lpb_pkg::SUM_W'(s6_qc_ff);
      end else begin
         s6_sa = lpb_pkg::SUM_W'(s6_base_ff[0]) + lpb_pkg::SUM_W'(s6_qa_ff);
         s6_sb = lpb_pkg::SUM_W'(s6_base_ff[1]) + lpb_pkg::SUM_W'(s6_qb_ff);
         s6_sc = lpb_pkg::SUM_W'(s6_base_ff[2]) + lpb_pkg::SUM_W'(s6_qc_ff);
      end
      s6_fa = clamp_q(s6_sa, s6_sat_a);
      s6_fb = clamp_q(s6_sb, s6_sat_b);
      s6_fc = clamp_q(s6_sc, s6_sat_c);

      out_data_in          = '0;
      out_data_in.row      = s6_row_ff;
      out_data_in.side     = s6_side_ff;
      out_data_in.rho      = s6_rho_ff;
      out_data_in.m_neg    = s6_m_neg_ff;
      out_data_in.m_zero   = s6_m_zero_ff;
      out_data_in.rho_zero = s6_rho_zero_ff;
      out_data_in.ovf      = s6_ovf_ff;
      out_data_in.rem      = s6_rem_ff;
      out_data_in.nlow     = s6_nlow_ff;
      if (s6_side_ff == lpb_pkg::SIDE_NONE) begin
         out_data_in.fill_first  = s6_base_ff[0];
         out_data_in.fill_second = s6_base_ff[1];
         out_data_in.fill_third  = s6_base_ff[2];
         out_data_in.fill_sat    = 1'b0;
      end else begin
         out_data_in.fill_first  = s6_fa;
         out_data_in.fill_second = s6_fb;
         out_data_in.fill_third  = s6_fc;
         out_data_in.fill_sat    = s6_sat_a | s6_sat_b | s6_sat_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         out_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_col_ff <= in_data[lpb_pkg::COL_LSB +: lpb_pkg::COL_W];
         s1_row_ff <= in_data[lpb_pkg::ROW_LSB +: lpb_pkg::ROW_W];
         s1_rho_ff <= in_data[lpb_pkg::RHO_LSB +: lpb_pkg::RHO_W];
         for (int k = 0; k < lpb_pkg::NUM_DIR; k++) begin
            s1_f_ff[k] <= in_data[lpb_pkg::F0_LSB + k * F_W +: F_W];
         end

         s2_row_ff  <= s1_row_ff;
         s2_rho_ff  <= s1_rho_ff;
         s2_side_ff <= s1_side;
         s2_sc_ff   <= s1_sc;
         s2_sw_ff   <= s1_sw;
         s2_se_ff   <= s1_se;
         s2_d_ff    <= s1_d;

         s3_row_ff  <= s2_row_ff;
         s3_rho_ff  <= s2_rho_ff;
         s3_side_ff <= s2_side_ff;
         s3_m_ff    <= s2_m;
         s3_d3_ff   <= s2_d3;

         s4_row_ff      <= s3_row_ff;
         s4_rho_ff      <= s3_rho_ff;
         s4_side_ff     <= s3_side_ff;
         s4_xa_ff       <= s3_xa;
         s4_xb_ff       <= s3_xb;
         s4_xc_ff       <= s3_xc;
         s4_na_ff       <= s3_t2[X_W-1];
         s4_nb_ff       <= s3_tb[X_W-1];
         s4_nc_ff       <= s3_tc[X_W-1];
         s4_n_ff        <= s3_n;
         s4_m_neg_ff    <= s3_m_ff[M_W-1];
         s4_m_zero_ff   <= (s3_m_ff == '0);
         s4_rho_zero_ff <= (s3_rho_ff == '0);

         s5_row_ff      <= s4_row_ff;
         s5_rho_ff      <= s4_rho_ff;
         s5_side_ff     <= s4_side_ff;
         s5_pa_ff       <= s4_pa;
         s5_pb_ff       <= s4_pb;
         s5_pc_ff       <= s4_pc;
         s5_xa_ff       <= s4_xa_ff;
         s5_xb_ff       <= s4_xb_ff;
         s5_xc_ff       <= s4_xc_ff;
         s5_na_ff       <= s4_na_ff;
         s5_nb_ff       <= s4_nb_ff;
         s5_nc_ff       <= s4_nc_ff;
         s5_m_neg_ff    <= s4_m_neg_ff;
         s5_m_zero_ff   <= s4_m_zero_ff;
         s5_rho_zero_ff <= s4_rho_zero_ff;
         s5_ovf_ff      <= s4_ovf;
         s5_rem_ff      <= s4_top[lpb_pkg::RHO_W-1:0];
         s5_nlow_ff     <= s4_n_ff[lpb_pkg::QB-1:0];

         s6_row_ff      <= s5_row_ff;
         s6_rho_ff      <= s5_rho_ff;
         s6_side_ff     <= s5_side_ff;
         s6_qa_ff       <= div3_fix(s5_pa_ff, s5_xa_ff, s5_na_ff);
         s6_qb_ff       <= div3_fix(s5_pb_ff, s5_xb_ff, s5_nb_ff);
         s6_qc_ff       <= div3_fix(s5_pc_ff, s5_xc_ff, s5_nc_ff);
         s6_m_neg_ff    <= s5_m_neg_ff;
         s6_m_zero_ff   <= s5_m_zero_ff;
         s6_rho_zero_ff <= s5_rho_zero_ff;
         s6_ovf_ff      <= s5_ovf_ff;
         s6_rem_ff      <= s5_rem_ff;
         s6_nlow_ff     <= s5_nlow_ff;

         for (int k = 0; k < 3; k++) begin
            s2_base_ff[k] <= s1_base[k];
            s3_base_ff[k] <= s2_base_ff[k];
            s4_base_ff[k] <= s3_base_ff[k];
            s5_base_ff[k] <= s4_base_ff[k];
            s6_base_ff[k] <= s5_base_ff[k];
         end

         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// File: hw/rtl/lpb_cell.sv
module lpb_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  lpb_pkg::chain_type  in_data,
   output logic                out_valid,
   output lpb_pkg::chain_type  out_data
);

   localparam int RHO_W = lpb_pkg::RHO_W;
   localparam int QB    = lpb_pkg::QB;

   logic [RHO_W:0]      trial;
   logic                take;
   lpb_pkg::chain_type  data_in, data_ff;
   logic                valid_ff;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial        = {in_data.rem, in_data.nlow[QB-1]};
      take         = trial >= {1'b0, in_data.rho};
      data_in      = in_data;
      data_in.rem  = take ? RHO_W'(trial - {1'b0, in_data.rho}) : trial[RHO_W-1:0];
      data_in.nlow = {in_data.nlow[QB-2:0], 1'b0};
      data_in.quot = {in_data.quot[QB-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/lpb_out.sv
module lpb_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  lpb_pkg::chain_type          in_data,
   output logic                        ready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lpb_pkg::OUT_W-1:0]   rsp_tdata,
   output logic [lpb_pkg::SIDE_W-1:0]  rsp_tuser
);

   localparam int F_W = lpb_pkg::F_W;
   localparam int QB  = lpb_pkg::QB;
   localparam int CNT_W = $clog2(lpb_pkg::BUF_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(lpb_pkg::BUF_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic signed [F_W-1:0] ux;
   logic                  ux_sat;
   logic [QB-1:0]         neg_q;
   lpb_pkg::res_type      result;

   lpb_pkg::res_type  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   always_comb begin
      neg_q  = '0 - in_data.quot;
      ux     = '0;
      ux_sat = 1'b0;
      priority if (in_data.side == lpb_pkg::SIDE_NONE) begin
         ux = '0;
      end else if (in_data.rho_zero) begin
         if (in_data.m_zero) begin
            ux = '0;
         end else if (in_data.m_neg) begin
            ux     = lpb_pkg::Q_MIN;
            ux_sat = 1'b1;
         end else begin
            ux     = lpb_pkg::Q_MAX;
            ux_sat = 1'b1;
         end
      end else if (in_data.m_neg) begin
         if (in_data.ovf || (in_data.quot > lpb_pkg::QNEG_LIM)) begin
            ux     = lpb_pkg::Q_MIN;
            ux_sat = 1'b1;
         end else begin
            ux = neg_q[F_W-1:0];
         end
      end else begin
         if (in_data.ovf || (in_data.quot > lpb_pkg::QPOS_LIM)) begin
            ux     = lpb_pkg::Q_MAX;
            ux_sat = 1'b1;
         end else begin
            ux = in_data.quot[F_W-1:0];
         end
      end

      result.side = in_data.side;
      result.data = lpb_pkg::OUT_W'({in_data.fill_sat | ux_sat,
                                     in_data.fill_third,
                                     in_data.fill_second,
                                     in_data.fill_first,
                                     {F_W{1'b0}},
                                     ux,
                                     in_data.rho,
                                     in_data.row});
   end

   // Two-entry output buffer; ready depends on the registered fill level only.
   assign ready      = count_ff != CNT_FULL;
   assign rsp_tvalid = count_ff != '0;
   assign push       = in_valid && ready;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop && (count_ff == CNT_FULL)) begin
         head_in = tail_ff;
      end else if (push && ((count_ff == '0) || pop)) begin
         head_in = result;
      end
      if (push && !pop && (count_ff == CNT_ONE)) begin
         tail_in = result;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tdata = head_ff.data;
   assign rsp_tuser = head_ff.side;

endmodule

// File: hw/rtl/lattice_pressure_boundary_top.sv
// A result reaches rsp_tvalid after its request transaction has passed through the registers of
// seven front stages, one cell per quotient bit of the velocity divider, and one output register.
// Throughput: one transaction per cycle while req_tready is high; a two-entry output buffer
// absorbs stalls on rsp_tready and stalls the whole pipeline while full. Reset is synchronous
// and active high: it empties the pipeline and the output buffer and sets grid_width to 256.
module lattice_pressure_boundary_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // node_column, node_row, target_density, f_rest, f_east, f_north, f_west,
   // f_south, f_northeast, f_northwest, f_southwest, f_southeast
   input  logic [lpb_pkg::IN_W-1:0]    req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // row_out, density_out, velocity_x, velocity_y, fill_first, fill_second,
   // fill_third, saturated
   output logic [lpb_pkg::OUT_W-1:0]   rsp_tdata,
   // side_status
   output logic [lpb_pkg::SIDE_W-1:0]  rsp_tuser,
   input  logic                        csr_wr_en,
   input  logic [lpb_pkg::GW_W-1:0]    csr_wr_data
);

   localparam int QB = lpb_pkg::QB;

   logic                enable;
   logic                chain_valid [QB+1];
   lpb_pkg::chain_type  chain_data  [QB+1];

   assign req_tready = enable;

   lpb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (req_tvalid),
      .in_data     (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .out_valid   (chain_valid[0]),
      .out_data    (chain_data[0])
   );

   for (genvar i = 0; i < QB; i++) begin : g_cell
      lpb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   lpb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[QB]),
      .in_data    (chain_data[QB]),
      .ready      (enable),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: tb/lattice_pressure_boundary_top_test.sv
module lattice_pressure_boundary_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lpb_pkg::*;

   localparam int unsigned RUN_LIMIT = 400000;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int NUM_PHASES = 10;
   localparam int PHASE_NODES = 100;
   localparam logic [F_W-1:0] ONE = 24'h100000;
   localparam logic [F_W-1:0] FMAX = 24'h7FFFFF;
   localparam logic [F_W-1:0] FMIN = 24'h800000;

   // Packed so that the struct matches req_tdata bit for bit, node_column lowest.
   typedef struct packed {
      logic [NUM_DIR-1:0][F_W-1:0] f;
      logic [RHO_W-1:0]            rho;
      logic [ROW_W-1:0]            row;
      logic [COL_W-1:0]            col;
   } node_item;

   // Matches {rsp_tuser, rsp_tdata} with row_out lowest.
   typedef struct packed {
      side_type         side;
      logic             saturated;
      logic [F_W-1:0]   fill_third;
      logic [F_W-1:0]   fill_second;
      logic [F_W-1:0]   fill_first;
      logic [F_W-1:0]   vel_y;
      logic [F_W-1:0]   vel_x;
      logic [RHO_W-1:0] rho;
      logic [ROW_W-1:0] row;
   } boundary_result;

   typedef struct {
      node_item       item;
      bit             typed;
      boundary_result want;
   } directed_row;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [IN_W-1:0]   req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [OUT_W-1:0]  rsp_tdata;
   logic [SIDE_W-1:0] rsp_tuser;
   logic              csr_wr_en = 1'b0;
   logic [GW_W-1:0]   csr_wr_data = '0;

   logic [GW_W-1:0]   grid_shadow = GW_RESET;
   boundary_result    expected_q[$];
   bit                steady = 1'b0;
   bit                hold_rsp = 1'b0;
   int unsigned       cycles = 0;
   int unsigned       mismatches = 0;
   int unsigned       results_seen = 0;
   int unsigned       nodes_sent = 0;
   int unsigned       west_count = 0;
   int unsigned       east_count = 0;
   int unsigned       none_count = 0;
   int unsigned       sat_count = 0;

   lattice_pressure_boundary_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      return steady ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp_q(longint v, inout bit sat);
      longint hi;
      longint lo;
      hi = longint'(Q_MAX);
      lo = longint'(Q_MIN);
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic boundary_result predict_boundary(node_item n, logic [GW_W-1:0] width);
      longint fv [NUM_DIR];
      longint rho, m, d, ux, a, b, c, r0, r1, r2;
      bit sat;
      boundary_result res;
      sat = 1'b0;
      ux = 0;
      for (int k = 0; k < NUM_DIR; k++) fv[k] = longint'($signed(n.f[k]));
      rho = longint'(n.rho);
      d = fv[4] - fv[2];
      res.row = n.row;
      res.rho = n.rho;
      res.vel_y = '0;
      if (n.col == '0) res.side = SIDE_WEST;
      else if (longint'(n.col) == longint'(width) - 1) res.side = SIDE_EAST;
      else res.side = SIDE_NONE;
      if (res.side == SIDE_NONE) begin
         res.vel_x = '0;
         res.fill_first = n.f[1];
         res.fill_second = n.f[5];
         res.fill_third = n.f[8];
      end else begin
         if (res.side == SIDE_WEST) m = rho - (fv[0] + fv[2] + fv[4] + 2 * (fv[3] + fv[6] + fv[7]));
         else m = (fv[0] + fv[2] + fv[4] + 2 * (fv[1] + fv[5] + fv[8])) - rho;
         if (rho == 0) begin
            ux = (m > 0) ? longint'(Q_MAX) : (m < 0) ? longint'(Q_MIN) : 0;
            sat = (m != 0);
         end else begin
            ux = clamp_q(round_div(m * (longint'(1) << FRAC_BITS), rho), sat);
         end
         a = round_div(2 * m, 3);
         b = round_div(m + 3 * d, 6);
         c = round_div(m - 3 * d, 6);
         if (res.side == SIDE_WEST) begin
            r0 = fv[3] + a;
            r1 = fv[7] + b;
            r2 = fv[6] + c;
         end else begin
            r0 = fv[1] - a;
            r1 = fv[5] - b;
            r2 = fv[8] - c;
         end
         r0 = clamp_q(r0, sat);
         r1 = clamp_q(r1, sat);
         r2 = clamp_q(r2, sat);
         res.vel_x = ux[F_W-1:0];
         res.fill_first = r0[F_W-1:0];
         res.fill_second = r1[F_W-1:0];
         res.fill_third = r2[F_W-1:0];
      end
      res.saturated = sat;
      return res;
   endfunction

   function automatic node_item random_node(logic [GW_W-1:0] width);
      node_item n;
      int unsigned shape;
      n.row = ROW_W'($urandom);
      case ($urandom_range(0, 5))
         0, 1: n.col = '0;
         2, 3: n.col = COL_W'(width - 1'b1);
         4: n.col = width[COL_W-1:0];
         default: n.col = COL_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: n.rho = '0;
         1: n.rho = '1;
         2: n.rho = RHO_W'($urandom_range(1, 15));
         3: n.rho = RHO_W'($urandom);
         default: n.rho = RHO_W'($urandom_range(32'h80000, 32'h200000));
      endcase
      shape = $urandom_range(0, 3);
      for (int k = 0; k < NUM_DIR; k++) begin
         if (shape == 0) n.f[k] = F_W'($urandom);
         else n.f[k] = F_W'($urandom_range(0, 32'hC0000) - 32'h30000);
      end
      return n;
   endfunction

   task automatic send_node(node_item n, bit typed, boundary_result want);
      int unsigned gap;
      boundary_result exp_res;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= IN_W'(n);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      exp_res = typed ? want : predict_boundary(n, grid_shadow);
      expected_q = {expected_q, exp_res};
      nodes_sent++;
      case (exp_res.side)
         SIDE_WEST: west_count++;
         SIDE_EAST: east_count++;
         default: none_count++;
      endcase
      if (exp_res.saturated) sat_count++;
      @(negedge clock);
   endtask

   task automatic write_grid_width(logic [GW_W-1:0] value);
      while (expected_q.size() != 0) @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      grid_shadow = value;
   endtask

   task automatic compare_field(string label, logic [F_W-1:0] want, logic [F_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch in %s of result %0d: expected %h, got %h",
                     label, results_seen, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      boundary_result got;
      boundary_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = boundary_result'({rsp_tuser, rsp_tdata[OUT_USED-1:0]});
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Result %0d arrived with no transaction waiting for it", results_seen);
         end else begin
            want = expected_q.pop_front();
            compare_field("row_out", F_W'(want.row), F_W'(got.row));
            compare_field("side_status", F_W'(want.side), F_W'(got.side));
            compare_field("density_out", F_W'(want.rho), F_W'(got.rho));
            compare_field("velocity_x", want.vel_x, got.vel_x);
            compare_field("velocity_y", want.vel_y, got.vel_y);
            compare_field("fill_first", want.fill_first, got.fill_first);
            compare_field("fill_second", want.fill_second, got.fill_second);
            compare_field("fill_third", want.fill_third, got.fill_third);
            compare_field("saturated", F_W'(want.saturated), F_W'(got.saturated));
         end
      end
   end

   initial begin : rsp_side
      int unsigned gap;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && !reset));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("Timed out with %0d results still outstanding", expected_q.size());
         $display("lattice_pressure_boundary_top_test failed");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row rows[$];
      logic [GW_W-1:0] phase_width [NUM_PHASES];
      boundary_result no_want;
      no_want = '0;
      phase_width = '{13'd2, 13'd4096, 13'd1, 13'd0, 13'd8191,
                      13'd0, 13'd0, 13'd256, 13'd0, 13'd0};
      phase_width[5] = GW_W'($urandom_range(2, 4096));
      phase_width[6] = GW_W'($urandom_range(2, 4096));
      phase_width[8] = GW_W'($urandom_range(2, 4096));
      phase_width[9] = GW_W'($urandom_range(2, 4096));

      // Unit density with no known distributions: the fills are 2/3 and 1/6 of it.
      rows = {rows, directed_row'{
         item: node_item'{f: '{default: '0}, rho: RHO_W'(ONE), row: 12'd7, col: 12'd0},
         typed: 1'b1,
         want: boundary_result'{side: SIDE_WEST, saturated: 1'b0, fill_third: 24'd174763,
                                fill_second: 24'd174763, fill_first: 24'd699051,
                                vel_y: '0, vel_x: ONE, rho: RHO_W'(ONE), row: 12'd7}}};
      rows = {rows, directed_row'{
         item: node_item'{f: '{default: '0}, rho: RHO_W'(ONE), row: 12'd8, col: 12'd255},
         typed: 1'b1,
         want: boundary_result'{side: SIDE_EAST, saturated: 1'b0, fill_third: 24'd174763,
                                fill_second: 24'd174763, fill_first: 24'd699051,
                                vel_y: '0, vel_x: 24'hF00000, rho: RHO_W'(ONE), row: 12'd8}}};
      rows = {rows, directed_row'{
         item: node_item'{f: '{default: FMAX}, rho: '1, row: 12'd4095, col: 12'd1},
         typed: 1'b1,
         want: boundary_result'{side: SIDE_NONE, saturated: 1'b0, fill_third: FMAX,
                                fill_second: FMAX, fill_first: FMAX,
                                vel_y: '0, vel_x: '0, rho: '1, row: 12'd4095}}};
      rows = {rows, directed_row'{
         item: node_item'{f: '{default: FMIN}, rho: 23'd1, row: 12'd0, col: 12'd4095},
         typed: 1'b1,
         want: boundary_result'{side: SIDE_NONE, saturated: 1'b0, fill_third: FMIN,
                                fill_second: FMIN, fill_first: FMIN,
                                vel_y: '0, vel_x: '0, rho: 23'd1, row: 12'd0}}};
      rows = {rows, directed_row'{
         item: node_item'{f: '{1: 24'h123456, 5: 24'hABCDEF, 8: 24'h000001,
                              default: 24'h5A5A5A},
                          rho: RHO_W'(ONE), row: 12'd100, col: 12'd256},
         typed: 1'b1,
         want: boundary_result'{side: SIDE_NONE, saturated: 1'b0, fill_third: 24'h000001,
                                fill_second: 24'hABCDEF, fill_first: 24'h123456,
                                vel_y: '0, vel_x: '0, rho: RHO_W'(ONE), row: 12'd100}}};
      rows = {rows, directed_row'{
         item: node_item'{f: '{default: '0}, rho: '0, row: 12'd1, col: 12'd0},
         typed: 1'b1,
         want: boundary_result'{side: SIDE_WEST, saturated: 1'b0, fill_third: '0,
                                fill_second: '0, fill_first: '0,
                                vel_y: '0, vel_x: '0, rho: '0, row: 12'd1}}};
      rows = {rows, directed_row'{
         item: node_item'{f: '{3: 24'd1, default: '0}, rho: '0, row: 12'd2, col: 12'd0},
         typed: 1'b1,
         want: boundary_result'{side: SIDE_WEST, saturated: 1'b1, fill_third: '0,
                                fill_second: '0, fill_first: '0,
                                vel_y: '0, vel_x: FMIN, rho: '0, row: 12'd2}}};
      rows = {rows, directed_row'{
         item: node_item'{f: '{1: 24'd1, default: '0}, rho: '0, row: 12'd3, col: 12'd255},
         typed: 1'b1,
         want: boundary_result'{side: SIDE_EAST, saturated: 1'b1, fill_third: '0,
                                fill_second: '0, fill_first: '0,
                                vel_y: '0, vel_x: FMAX, rho: '0, row: 12'd3}}};
      rows = {rows, directed_row'{node_item'{f: '{default: FMIN}, rho: '1, row: 12'd9,
                                             col: 12'd0}, 1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{default: FMAX}, rho: '1, row: 12'd10,
                                             col: 12'd0}, 1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{default: FMIN}, rho: '1, row: 12'd11,
                                             col: 12'd255}, 1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{default: FMAX}, rho: '1, row: 12'd12,
                                             col: 12'd255}, 1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{default: '0}, rho: 23'd1, row: 12'd13,
                                             col: 12'd0}, 1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{0: 24'd466034, 1: 24'd116508,
                                                 2: 24'd116508, 3: 24'd116508,
                                                 4: 24'd116508, default: 24'd29127},
                                             rho: RHO_W'(ONE), row: 12'd14, col: 12'd0},
                                  1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{0: 24'd466034, 1: 24'd116508,
                                                 2: 24'd116508, 3: 24'd116508,
                                                 4: 24'd116508, default: 24'd29127},
                                             rho: RHO_W'(ONE), row: 12'd15, col: 12'd255},
                                  1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{default: '0}, rho: 23'd3, row: 12'd16,
                                             col: 12'd0}, 1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{0: 24'd3, default: '0}, rho: '0,
                                             row: 12'd17, col: 12'd0}, 1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{0: 24'h1FFFFF, default: '0},
                                             rho: 23'h200000, row: 12'd18, col: 12'd0},
                                  1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{2: 24'h040000, 4: 24'hFC0000,
                                                 default: '0},
                                             rho: RHO_W'(ONE), row: 12'd19, col: 12'd0},
                                  1'b0, no_want}};
      rows = {rows, directed_row'{node_item'{f: '{2: 24'hFC0000, 4: 24'h040000,
                                                 default: '0},
                                             rho: RHO_W'(ONE), row: 12'd20, col: 12'd255},
                                  1'b0, no_want}};

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_node(rows[i].item, rows[i].typed, rows[i].want);
      req_tvalid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_grid_width(phase_width[p]);
         steady = (p % 3 == 1) || (p == 5);
         if (p == 5) hold_rsp = 1'b1;
         for (int i = 0; i < PHASE_NODES; i++) send_node(random_node(grid_shadow), 1'b0, no_want);
         req_tvalid <= 1'b0;
      end
      steady = 1'b0;

      while (expected_q.size() != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d boundary nodes under %0d grid_width settings, with one long output stall.",
               nodes_sent, NUM_PHASES + 1);
      $display("West %0d, east %0d, unsupported %0d; %0d results clamped.",
               west_count, east_count, none_count, sat_count);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("lattice_pressure_boundary_top_test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("lattice_pressure_boundary_top_test failed");
      end
      $finish;
   end

endmodule
